>>> sv/segr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segr_pkg
// Shared types and codes of the segmented regression basis row core.
// ----------------------------------------------------------------------------
package segr_pkg;

  typedef struct packed {
    logic [31:0] loc;
    logic [31:0] slope;
    logic [31:0] jump;
    logic [15:0] gap;
  } bp_entry_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] tc;
    logic [31:0] jc;
    logic [31:0] z;
    logic [30:0] w;
    logic        flag;
  } bp_result_t;

  // register map, word index
  localparam logic [2:0] REG_TERM_KIND     = 3'd0;
  localparam logic [2:0] REG_LINEAR_ENABLE = 3'd1;
  localparam logic [2:0] REG_LINEAR_SLOPE  = 3'd2;
  localparam logic [2:0] REG_RANGE_LOW     = 3'd3;
  localparam logic [2:0] REG_RANGE_HIGH    = 3'd4;
  localparam logic [2:0] REG_ACTIVE_BP     = 3'd5;

  localparam logic [1:0] KIND_CONT = 2'd0;
  localparam logic [1:0] KIND_JUMP = 2'd1;
  localparam logic [1:0] KIND_BOTH = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
  localparam logic [30:0]        W_MAX   = 31'h7fffffff;

endpackage

>>> sv/segr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segr_cell
// One breakpoint cell: holds a table entry and one stage of the result chain.
// ----------------------------------------------------------------------------
module segr_cell
  import segr_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  bp_entry_t  wr_entry,
  output bp_entry_t  entry,
  input  logic       shift_en,
  input  bp_result_t res_in,
  output bp_result_t res_out
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= wr_entry;
    end
    // results move one cell toward the head
    if (shift_en) begin
      res_out <= res_in;
    end
  end

endmodule

>>> sv/segr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module segr_div #(
  parameter int NW = 34,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, quo[NW-1]};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
    end else if (busy) begin
      if (!diff[DW]) begin
        rem <= diff[DW-1:0];
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial[DW-1:0];
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule

>>> sv/segregation_placeholder_never.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segr_sat
// Saturation of a wide signed value to a 32-bit signed field.
// ----------------------------------------------------------------------------
module segr_sat
  import segr_pkg::*;
(
  input  logic signed [63:0] val,
  output logic [31:0]        res,
  output logic               sat
);

  always_comb begin
    if (val > I32_MAX) begin
      res = 32'h7fffffff;
      sat = 1'b1;
    end else if (val < I32_MIN) begin
      res = 32'h80000000;
      sat = 1'b1;
    end else begin
      res = val[31:0];
      sat = 1'b0;
    end
  end

endmodule

>>> sv/segmented_regression_basis_row_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_regression_basis_row_core
// Builds one row of a segmented regression design block per sample.
// ----------------------------------------------------------------------------
// A load transfer writes one breakpoint entry. A sample walks the active
// breakpoints (n, at most 8) one at a time through a shared datapath; for
// jump kinds each breakpoint waits on the restoring divider for the weight
// unless the divisor is zero. Results then leave one per cycle, while
// out_ready is high, from the head of the cell chain. A new item is taken
// once the last result of a sample has been transferred.
module segmented_regression_basis_row_core
  import segr_pkg::*;
#(
  parameter int MAX_BREAKPOINTS = 8,
  parameter int FRAC_BITS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [2:0]  slot,
  input  logic [31:0] x_sample,
  input  logic [31:0] bp_location,
  input  logic [31:0] bp_slope_change,
  input  logic [31:0] bp_jump,
  input  logic [15:0] bp_gap_scale,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  bp_index,
  output logic [31:0] linear_col,
  output logic [31:0] trunc_col,
  output logic [31:0] jacobian_col,
  output logic [31:0] z_col,
  output logic [30:0] w_col,
  output logic [31:0] row_value,
  output logic        last,
  output logic        saturated
);

  localparam int NW  = ((2 * FRAC_BITS > 33) ? 2 * FRAC_BITS : 33) + 1;
  localparam int DW  = 33;
  localparam int IDXW = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
  localparam int CW  = $clog2(MAX_BREAKPOINTS + 1);
  localparam logic [3:0] N_LIM = (MAX_BREAKPOINTS < 8) ? 4'(MAX_BREAKPOINTS) : 4'd8;
  localparam logic signed [63:0] HALF64 = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic [NW-1:0] WNUM = {{(NW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS - 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_LIN   = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_COL   = 12'b000000001000,
    S_MUL   = 12'b000000010000,
    S_ACC   = 12'b000000100000,
    S_DIV   = 12'b000001000000,
    S_ZMUL  = 12'b000010000000,
    S_ZOUT  = 12'b000100000000,
    S_PUSH  = 12'b001000000000,
    S_ALIGN = 12'b010000000000,
    S_EMIT  = 12'b100000000000
  } state_t;

  state_t state;

  // configuration
  logic [1:0]  term_kind;
  logic        linear_enable;
  logic [31:0] linear_slope;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic [3:0]  active_bp;

  // per-sample and per-breakpoint registers
  logic signed [31:0] x_reg;
  logic [3:0]         n_reg;
  logic [3:0]         j;
  logic [3:0]         e;
  logic [CW-1:0]      align_cnt;
  logic signed [63:0] acc;
  logic signed [31:0] p;
  logic signed [31:0] d;
  logic signed [31:0] k;
  logic [15:0]        c;
  logic signed [32:0] t;
  logic               gt;
  logic [31:0]        tc;
  logic [31:0]        jc;
  logic               flag;
  logic signed [63:0] m1;
  logic signed [49:0] m2;
  logic signed [50:0] m3;
  logic [31:0]        xs;
  logic [30:0]        w;
  logic signed [63:0] m4;
  logic [31:0]        z;
  logic [31:0]        val;
  logic               vflag;

  logic delta_on;
  logic jump_on;
  assign delta_on = (term_kind == KIND_CONT) || (term_kind == KIND_BOTH);
  assign jump_on  = (term_kind == KIND_JUMP) || (term_kind == KIND_BOTH);

  // ---------------------------------------------------------------- config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_kind     <= KIND_CONT;
      linear_enable <= 1'b0;
      linear_slope  <= '0;
      range_low     <= '0;
      range_high    <= 32'(1) << FRAC_BITS;
      active_bp     <= 4'd1;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TERM_KIND:     term_kind     <= pwdata[1:0];
        REG_LINEAR_ENABLE: linear_enable <= pwdata[0];
        REG_LINEAR_SLOPE:  linear_slope  <= pwdata;
        REG_RANGE_LOW:     range_low     <= pwdata;
        REG_RANGE_HIGH:    range_high    <= pwdata;
        REG_ACTIVE_BP:     active_bp     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_TERM_KIND:     prdata = {30'd0, term_kind};
      REG_LINEAR_ENABLE: prdata = {31'd0, linear_enable};
      REG_LINEAR_SLOPE:  prdata = linear_slope;
      REG_RANGE_LOW:     prdata = range_low;
      REG_RANGE_HIGH:    prdata = range_high;
      REG_ACTIVE_BP:     prdata = {28'd0, active_bp};
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- cell chain
  bp_entry_t  wr_entry;
  bp_entry_t  entries [MAX_BREAKPOINTS];
  bp_result_t res_q   [MAX_BREAKPOINTS];
  bp_result_t tail_in;
  bp_result_t head;
  logic       load_go;
  logic       shift_en;
  logic       out_xfer;

  assign load_go  = in_valid && in_ready && (cmd == CMD_LOAD);
  assign out_xfer = out_valid && out_ready;
  assign shift_en = (state == S_PUSH) || (state == S_ALIGN) || out_xfer;
  assign wr_entry = '{loc: bp_location, slope: bp_slope_change, jump: bp_jump,
                      gap: bp_gap_scale};

  always_comb begin
    tail_in = '0;
    if (state == S_PUSH) begin
      tail_in = '{idx: j[2:0], tc: tc, jc: jc, z: z, w: w, flag: flag};
    end
  end

  for (genvar i = 0; i < MAX_BREAKPOINTS; i++) begin : g_cell
    bp_result_t cell_in;
    if (i == MAX_BREAKPOINTS - 1) begin : g_tail
      assign cell_in = tail_in;
    end else begin : g_mid
      assign cell_in = res_q[i+1];
    end
    segr_cell u_cell (
      .clk      (clk),
      .wr_en    (load_go && (32'(slot) == i)),
      .wr_entry (wr_entry),
      .entry    (entries[i]),
      .shift_en (shift_en),
      .res_in   (cell_in),
      .res_out  (res_q[i])
    );
  end

  assign head = res_q[0];

  // ---------------------------------------------------------------- datapath
  bp_entry_t          cur;
  logic [IDXW-1:0]    j_idx;
  logic signed [63:0] r2;
  logic signed [63:0] r3;
  logic signed [63:0] xs_raw;
  logic [31:0]        xs_sat;
  logic               xs_flag;
  logic signed [32:0] dxp;
  logic [DW-1:0]      ad;
  logic               div_start;
  logic               div_done;
  logic [NW-1:0]      div_q;
  logic signed [63:0] z_raw;
  logic [31:0]        z_sat;
  logic               z_flag;
  logic [31:0]        v_sat;
  logic               v_flag;
  logic [16:0]        keep;
  logic [3:0]         n_new;

  assign j_idx = IDXW'(j);
  assign cur   = entries[j_idx];
  assign keep  = 17'h10000 - {1'b0, c};
  assign n_new = (active_bp > N_LIM) ? N_LIM : active_bp;

  assign r2 = (64'(m2) + 64'sd32768) >>> 16;
  assign r3 = (64'(m3) + 64'sd32768) >>> 16;
  assign xs_raw = gt ? (64'(p) + r2 + r3) : (64'($signed(range_low)) + r3);

  segr_sat u_sat_xs (.val(xs_raw), .res(xs_sat), .sat(xs_flag));

  assign dxp = 33'($signed(xs)) - 33'(p);
  assign ad  = dxp[32] ? DW'(-dxp) : DW'(dxp);
  assign div_start = (state == S_ACC) && jump_on && (ad != '0);

  segr_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (WNUM + NW'(ad >> 1)),
    .den   (ad),
    .done  (div_done),
    .quo   (div_q)
  );

  assign z_raw = ((m4 + HALF64) >>> FRAC_BITS) + HALF64;
  segr_sat u_sat_z (.val(z_raw), .res(z_sat), .sat(z_flag));
  segr_sat u_sat_v (.val(acc), .res(v_sat), .sat(v_flag));

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      e     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && cmd == CMD_SAMPLE) begin
            x_reg <= $signed(x_sample);
            n_reg <= n_new;
            if (n_new != 4'd0) begin
              state <= S_LIN;
            end
          end
        end
        S_LIN: begin
          acc   <= linear_enable ?
                   (($signed(linear_slope) * x_reg + HALF64) >>> FRAC_BITS) : 64'sd0;
          j     <= '0;
          state <= S_RD;
        end
        S_RD: begin
          p     <= $signed(cur.loc);
          d     <= $signed(cur.slope);
          k     <= $signed(cur.jump);
          c     <= cur.gap;
          t     <= 33'(x_reg) - 33'($signed(cur.loc));
          gt    <= x_reg > $signed(cur.loc);
          flag  <= 1'b0;
          w     <= '0;
          z     <= '0;
          state <= S_COL;
        end
        S_COL: begin
          tc <= '0;
          jc <= '0;
          if (delta_on && t > 33'sd0) begin
            if (t > 33'sd2147483647) begin
              tc   <= 32'h7fffffff;
              flag <= 1'b1;
            end else begin
              tc <= t[31:0];
            end
          end
          if (term_kind == KIND_CONT && gt) begin
            if (d == 32'sh80000000) begin
              jc   <= 32'h7fffffff;
              flag <= 1'b1;
            end else begin
              jc <= 32'(-d);
            end
          end
          m2    <= $signed({1'b0, c}) * ((33'($signed(range_high))) - 33'(p));
          m3    <= (33'(x_reg) - (gt ? 33'(p) : 33'($signed(range_low))))
                   * $signed({1'b0, keep});
          state <= S_MUL;
        end
        S_MUL: begin
          m1 <= d * $signed(tc);
          xs <= xs_sat;
          if (jump_on && xs_flag) begin
            flag <= 1'b1;
          end
          state <= S_ACC;
        end
        S_ACC: begin
          acc <= acc + (delta_on ? ((m1 + HALF64) >>> FRAC_BITS) : 64'sd0)
                     + ((jump_on && gt) ? 64'(k) : 64'sd0);
          if (!jump_on) begin
            state <= S_PUSH;
          end else if (ad == '0) begin
            // zero divisor: weight pinned at its limit
            w     <= W_MAX;
            flag  <= 1'b1;
            state <= S_ZMUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (div_q > NW'(W_MAX)) begin
              w    <= W_MAX;
              flag <= 1'b1;
            end else begin
              w <= div_q[30:0];
            end
            state <= S_ZMUL;
          end
        end
        S_ZMUL: begin
          m4    <= $signed(xs) * $signed({1'b0, w});
          state <= S_ZOUT;
        end
        S_ZOUT: begin
          z <= z_sat;
          if (z_flag) begin
            flag <= 1'b1;
          end
          state <= S_PUSH;
        end
        S_PUSH: begin
          j <= j + 1'b1;
          if (j + 1'b1 == n_reg) begin
            val       <= v_sat;
            vflag     <= v_flag;
            e         <= '0;
            align_cnt <= CW'(MAX_BREAKPOINTS) - CW'(n_reg);
            state     <= (CW'(MAX_BREAKPOINTS) == CW'(n_reg)) ? S_EMIT : S_ALIGN;
          end else begin
            state <= S_RD;
          end
        end
        S_ALIGN: begin
          align_cnt <= align_cnt - 1'b1;
          if (align_cnt == CW'(1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            e <= e + 1'b1;
            if (e + 1'b1 == n_reg) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- outputs
  assign in_ready     = (state == S_IDLE);
  assign out_valid    = (state == S_EMIT);
  assign bp_index     = head.idx;
  assign linear_col   = linear_enable ? x_reg : 32'd0;
  assign trunc_col    = head.tc;
  assign jacobian_col = head.jc;
  assign z_col        = head.z;
  assign w_col        = head.w;
  assign row_value    = val;
  assign last         = (e + 1'b1 == n_reg);
  assign saturated    = head.flag || vflag;

`ifndef NO_ASSERTIONS
  // results leave in breakpoint order
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bp_index == e[2:0]))
    else $error("result out of breakpoint order");

  // nothing follows the last result of a sample
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> !out_valid)
    else $error("result after last");

  // weights only appear for jump kinds
  a_w_kind: assert property (@(posedge clk) disable iff (rst)
    (out_valid && w_col != '0) |-> (term_kind == KIND_JUMP || term_kind == KIND_BOTH))
    else $error("weight for a kind without jumps");

  // divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider result not awaited");
`endif

endmodule
